// ----- rtl/joystick_to_chassis_velocity_defines.svh -----
// Assertion macros shared by the checker of joystick_to_chassis_velocity.
`ifndef JOYSTICK_TO_CHASSIS_VELOCITY_DEFINES_SVH
`define JOYSTICK_TO_CHASSIS_VELOCITY_DEFINES_SVH

// same-cycle implication, off while in reset
`define JTCV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define JTCV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// checks what reset leaves behind, so it stays active during reset
`define JTCV_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

// ----- rtl/jtcv_pkg.sv -----
// Package for the joystick-to-chassis velocity mapper: widths, constants, types.
`default_nettype none

package jtcv_pkg;

    localparam int STICK_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int DZ_W       = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = STICK_W + GAIN_W + 1;  // stick x gain, signed
    localparam int XY_W       = 33;                    // CORDIC x/y, Q2.30 plus margin
    localparam int Z_W        = 34;                    // CORDIC angle, Q2.30
    localparam int SCL_W      = 26;                    // scaled stick, Q16.16
    localparam int TURN_W     = 28;                    // turn rate, Q16.16
    localparam int VEL_W      = 32;
    localparam int ROT_W      = SCL_W + XY_W;          // scaled stick x sin/cos
    localparam int IN_DATA_W  = 7 * STICK_W;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 3 * VEL_W;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 24;

    localparam logic signed [Z_W-1:0]  Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]  Q30_PI      = 34'sd3373259426;
    localparam logic signed [XY_W-1:0] Q30_GAIN    = 33'sd652032874;

    // arctan(2^-i), Q2.30, truncated
    localparam logic signed [Z_W-1:0] ATAN_TAB [0:CORDIC_MAX-1] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND        = 3'd0,
        CFG_MAX_SPEED_X     = 3'd1,
        CFG_MAX_SPEED_Y     = 3'd2,
        CFG_MAX_TURN_RATE   = 3'd3,
        CFG_FOLLOW_GAIN     = 3'd4,
        CFG_MAX_FOLLOW_RATE = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_FOLLOW,
        MODE_MANUAL,
        MODE_RC
    } t_mode;

    typedef struct packed {
        logic [DZ_W-1:0]   deadband;
        logic [GAIN_W-1:0] max_speed_x;
        logic [GAIN_W-1:0] max_speed_y;
        logic [GAIN_W-1:0] max_turn_rate;
        logic [GAIN_W-1:0] follow_gain;
        logic [GAIN_W-1:0] max_follow_rate;
    } t_cfg;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_vec;

    // data riding alongside the rotation
    typedef struct packed {
        logic                     rot;   // rotate fwd/side by the angle
        logic                     flip;  // angle was folded by pi
        logic signed [SCL_W-1:0]  fwd;
        logic signed [SCL_W-1:0]  side;
        logic signed [TURN_W-1:0] turn;
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/jtcv_front.sv -----
// Front end: dead zone, source select, gain products, rounding, angle fold.
`default_nettype none

module jtcv_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [jtcv_pkg::IN_USER_W-1:0]    i_user,
    input  logic [jtcv_pkg::IN_DATA_W-1:0]    i_data,
    input  jtcv_pkg::t_cfg                    i_cfg,
    output logic                              o_valid,
    output jtcv_pkg::t_vec                    o_vec,
    output jtcv_pkg::t_side                   o_side
);
    import jtcv_pkg::*;

    localparam logic signed [PROD_W-1:0] RND7  = PROD_W'(64);
    localparam logic signed [PROD_W-1:0] RND5  = PROD_W'(16);
    localparam logic signed [PROD_W:0]   RND7W = (PROD_W + 1)'(64);

    function automatic logic signed [STICK_W-1:0] dz_apply(
        input logic signed [STICK_W-1:0] v,
        input logic [DZ_W-1:0]           dz
    );
        logic signed [STICK_W:0] vs;
        logic signed [STICK_W:0] dzs;
        vs  = $signed({v[STICK_W-1], v});
        dzs = $signed({2'b00, dz});
        if ((vs > -dzs) && (vs < dzs)) begin
            return '0;
        end
        return v;
    endfunction

    // ---- step A: select and multiply ----
    logic signed [STICK_W-1:0] w_gx, w_gy, w_gw, w_yaw, w_c0, w_c1, w_c2;
    logic signed [STICK_W-1:0] w_fwd_in, w_side_in, w_turn_in;
    logic signed [PROD_W-1:0]  w_pf, w_ps, w_pt, w_py;
    logic signed [Z_W-1:0]     w_z0, w_z;
    logic                      w_flip;
    t_mode                     w_mode;

    assign w_gx  = i_data[0*STICK_W +: STICK_W];
    assign w_gy  = i_data[1*STICK_W +: STICK_W];
    assign w_gw  = i_data[2*STICK_W +: STICK_W];
    assign w_yaw = i_data[3*STICK_W +: STICK_W];
    assign w_c0  = dz_apply(i_data[4*STICK_W +: STICK_W], i_cfg.deadband);
    assign w_c1  = dz_apply(i_data[5*STICK_W +: STICK_W], i_cfg.deadband);
    assign w_c2  = dz_apply(i_data[6*STICK_W +: STICK_W], i_cfg.deadband);

    always_comb begin
        if (i_user[0]) begin
            w_mode = i_user[1] ? MODE_FOLLOW : MODE_MANUAL;
        end else begin
            w_mode = i_user[2] ? MODE_RC : MODE_OFF;
        end
    end

    // wheel has no dead zone
    assign w_fwd_in  = i_user[0] ? dz_apply(w_gy, i_cfg.deadband) : w_c1;
    assign w_side_in = i_user[0] ? dz_apply(w_gx, i_cfg.deadband) : w_c0;
    assign w_turn_in = i_user[0] ? w_gw : w_c2;

    assign w_pf = w_fwd_in  * $signed({1'b0, i_cfg.max_speed_x});
    assign w_ps = w_side_in * $signed({1'b0, i_cfg.max_speed_y});
    assign w_pt = w_turn_in * $signed({1'b0, i_cfg.max_turn_rate});
    assign w_py = w_yaw     * $signed({1'b0, i_cfg.follow_gain});

    // Q3.13 -> Q2.30, folded into [-pi/2, pi/2]
    assign w_z0 = $signed({w_yaw[STICK_W-1], w_yaw, 17'd0});

    always_comb begin
        w_z    = w_z0;
        w_flip = 1'b0;
        if (w_z0 > Q30_HALF_PI) begin
            w_z    = w_z0 - Q30_PI;
            w_flip = 1'b1;
        end else if (w_z0 < -Q30_HALF_PI) begin
            w_z    = w_z0 + Q30_PI;
            w_flip = 1'b1;
        end
    end

    logic                     r_a_valid;
    logic signed [PROD_W-1:0] r_a_pf, r_a_ps, r_a_pt, r_a_py;
    logic signed [Z_W-1:0]    r_a_z;
    logic                     r_a_flip;
    logic                     r_a_wneg;
    t_mode                    r_a_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pf   <= w_pf;
            r_a_ps   <= w_ps;
            r_a_pt   <= w_pt;
            r_a_py   <= w_py;
            r_a_z    <= w_z;
            r_a_flip <= w_flip;
            r_a_wneg <= w_gw[STICK_W-1];
            r_a_mode <= w_mode;
        end
    end

    // ---- step B: round to Q16.16, pick turn rate ----
    logic signed [PROD_W-1:0] w_f_sum, w_s_sum, w_t_sum, w_y_sum;
    logic signed [PROD_W:0]   w_rc_sum;
    logic signed [TURN_W-1:0] w_follow, w_lim, w_man, w_rc;
    t_side                    n_side;
    t_vec                     n_vec;

    assign w_f_sum  = r_a_pf + RND7;
    assign w_s_sum  = r_a_ps + RND7;
    assign w_t_sum  = r_a_pt + RND7;
    assign w_y_sum  = r_a_py + RND5;
    // receiver turn is negated before rounding
    assign w_rc_sum = RND7W - $signed({r_a_pt[PROD_W-1], r_a_pt});

    assign w_follow = $signed(w_y_sum[5 +: TURN_W]);
    assign w_lim    = $signed({4'd0, i_cfg.max_follow_rate, 8'd0});
    assign w_man    = TURN_W'($signed(w_t_sum[7 +: SCL_W]));
    assign w_rc     = TURN_W'($signed(w_rc_sum[7 +: TURN_W-1]));

    always_comb begin
        n_side.rot  = 1'b0;
        n_side.flip = r_a_flip;
        n_side.fwd  = $signed(w_f_sum[7 +: SCL_W]);
        n_side.side = $signed(w_s_sum[7 +: SCL_W]);
        n_side.turn = '0;
        unique case (r_a_mode)
            MODE_FOLLOW: begin
                n_side.rot = 1'b1;
                if (w_follow > w_lim) begin
                    n_side.turn = w_lim;
                end else if (w_follow < -w_lim) begin
                    n_side.turn = -w_lim;
                end else begin
                    n_side.turn = w_follow;
                end
            end
            MODE_MANUAL: begin
                n_side.turn = r_a_wneg ? w_man : '0;
            end
            MODE_RC: begin
                n_side.turn = w_rc;
            end
            MODE_OFF: begin
                n_side.fwd  = '0;
                n_side.side = '0;
            end
            default: begin
                n_side.fwd  = '0;
                n_side.side = '0;
            end
        endcase
    end

    always_comb begin
        n_vec.x = Q30_GAIN;
        n_vec.y = '0;
        n_vec.z = r_a_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= n_side;
            o_vec  <= n_vec;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jtcv_cordic_cell.sv -----
// One CORDIC rotation cell: a fixed shift and arctangent step, registered.
`default_nettype none

module jtcv_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  jtcv_pkg::t_vec  i_vec,
    input  jtcv_pkg::t_side i_side,
    output logic            o_valid,
    output jtcv_pkg::t_vec  o_vec,
    output jtcv_pkg::t_side o_side
);
    import jtcv_pkg::*;

    logic signed [XY_W-1:0] w_x, w_y, w_dx, w_dy;
    logic signed [Z_W-1:0]  w_z;
    t_vec                   n_vec;

    assign w_x  = i_vec.x;
    assign w_y  = i_vec.y;
    assign w_z  = i_vec.z;
    assign w_dx = w_y >>> STAGE;
    assign w_dy = w_x >>> STAGE;

    always_comb begin
        if (!w_z[Z_W-1]) begin
            n_vec.x = w_x - w_dx;
            n_vec.y = w_y + w_dy;
            n_vec.z = w_z - ATAN_TAB[STAGE];
        end else begin
            n_vec.x = w_x + w_dx;
            n_vec.y = w_y - w_dy;
            n_vec.z = w_z + ATAN_TAB[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_vec  <= n_vec;
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jtcv_back.sv -----
// Back end: rotate scaled sticks by sin/cos, round, and hold the result.
`default_nettype none

module jtcv_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  jtcv_pkg::t_vec                  i_vec,
    input  jtcv_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [jtcv_pkg::VEL_W-1:0]      o_vel_x,
    output logic [jtcv_pkg::VEL_W-1:0]      o_vel_y,
    output logic [jtcv_pkg::VEL_W-1:0]      o_vel_turn
);
    import jtcv_pkg::*;

    localparam int SUM_W = ROT_W + 3;
    localparam logic signed [SUM_W-1:0] RND30 = SUM_W'(64'd1 << 29);

    // ---- step 1: undo fold, four products ----
    logic signed [XY_W-1:0]  w_x, w_y, w_c, w_s;
    logic signed [SCL_W-1:0] w_fwd, w_side;

    assign w_x    = i_vec.x;
    assign w_y    = i_vec.y;
    assign w_c    = i_side.flip ? -w_x : w_x;
    assign w_s    = i_side.flip ? -w_y : w_y;
    assign w_fwd  = i_side.fwd;
    assign w_side = i_side.side;

    logic                    r_m_valid;
    logic signed [ROT_W-1:0] r_p_fc, r_p_ss, r_p_sc, r_p_fs;
    t_side                   r_m_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_fc   <= w_fwd  * w_c;
            r_p_ss   <= w_side * w_s;
            r_p_sc   <= w_side * w_c;
            r_p_fs   <= w_fwd  * w_s;
            r_m_side <= i_side;
        end
    end

    // ---- step 2: sum, round Q2.30 away ----
    // |result| stays below 2^26, so it fits the 32-bit output field without a clamp
    logic signed [SUM_W-1:0]  w_vx_sum, w_vy_sum;
    logic signed [SCL_W-1:0]  w_m_fwd, w_m_side;
    logic signed [TURN_W-1:0] w_m_turn;
    logic [VEL_W-1:0]         n_vel_x, n_vel_y, n_vel_turn;

    assign w_vx_sum = r_p_fc + r_p_ss + RND30;
    assign w_vy_sum = r_p_sc - r_p_fs + RND30;
    assign w_m_fwd  = r_m_side.fwd;
    assign w_m_side = r_m_side.side;
    assign w_m_turn = r_m_side.turn;

    always_comb begin
        if (r_m_side.rot) begin
            n_vel_x = w_vx_sum[30 +: VEL_W];
            n_vel_y = w_vy_sum[30 +: VEL_W];
        end else begin
            n_vel_x = VEL_W'(w_m_side);
            n_vel_y = VEL_W'(w_m_fwd);
        end
        n_vel_turn = VEL_W'(w_m_turn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_vel_x    <= n_vel_x;
            o_vel_y    <= n_vel_y;
            o_vel_turn <= n_vel_turn;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/joystick_to_chassis_velocity.sv -----
// Top level of the joystick-to-chassis velocity mapper.
`default_nettype none

// Turns one stick transaction into one chassis velocity transaction
// (vel_x, vel_y, vel_turn, Q16.16). The gimbal link sticks are used when
// gimbal_online is set: in follow mode the scaled sticks are rotated by
// yaw_error and the turn rate is follow_gain * yaw_error clamped to
// +-max_follow_rate; in manual mode the axes are swapped and the chassis
// turns only for a negative wheel. Otherwise the receiver sticks are used,
// and all outputs are zero when the receiver is offline as well.
// Rate: one transaction per clock unless the output stalls. Two front-end
// stages (gain products, rounding), one cell per CORDIC rotation step, then
// a multiply stage and the output register. The whole pipeline advances
// together; it holds only while a result sits in the output register and
// m_axis_tready is low, so s_axis_tready = !m_axis_tvalid ||
// m_axis_tready. Configuration is written through the cfg channel (always
// ready); the user must write it only while no transaction is in flight
// (the block does not check). Indexes past the last register are ignored.
module joystick_to_chassis_velocity #(
    parameter int CORDIC_STAGES = jtcv_pkg::CORDIC_STAGES_DEF   // 8..24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] gimbal_stick_x, [31:16] gimbal_stick_y, [47:32] gimbal_wheel,
    // [63:48] yaw_error, [79:64] rc_right_horizontal,
    // [95:80] rc_right_vertical, [111:96] rc_left_horizontal
    input  logic [jtcv_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] gimbal_online, [1] follow_enable, [2] receiver_online
    input  logic [jtcv_pkg::IN_USER_W-1:0]       s_axis_tuser,
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] vel_x, [63:32] vel_y, [95:64] vel_turn
    output logic [jtcv_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [jtcv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [jtcv_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import jtcv_pkg::*;

    // ---- configuration registers ----
    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEADBAND:        n_cfg.deadband        = i_cfg_data[DZ_W-1:0];
                CFG_MAX_SPEED_X:     n_cfg.max_speed_x     = i_cfg_data[GAIN_W-1:0];
                CFG_MAX_SPEED_Y:     n_cfg.max_speed_y     = i_cfg_data[GAIN_W-1:0];
                CFG_MAX_TURN_RATE:   n_cfg.max_turn_rate   = i_cfg_data[GAIN_W-1:0];
                CFG_FOLLOW_GAIN:     n_cfg.follow_gain     = i_cfg_data[GAIN_W-1:0];
                CFG_MAX_FOLLOW_RATE: n_cfg.max_follow_rate = i_cfg_data[GAIN_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ---- pipeline advance ----
    logic w_adv;
    logic w_out_valid;

    assign w_adv         = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = w_out_valid;

    // links between front end, cells and back end
    logic  w_vld  [0:CORDIC_STAGES];
    t_vec  w_vec  [0:CORDIC_STAGES];
    t_side w_side [0:CORDIC_STAGES];

    jtcv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (s_axis_tvalid && w_adv),
        .i_user  (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_valid (w_vld[0]),
        .o_vec   (w_vec[0]),
        .o_side  (w_side[0])
    );

    // chain of rotation cells, one per CORDIC step
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        jtcv_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_vld[g]),
            .i_vec   (w_vec[g]),
            .i_side  (w_side[g]),
            .o_valid (w_vld[g+1]),
            .o_vec   (w_vec[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    jtcv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (w_vld[CORDIC_STAGES]),
        .i_vec      (w_vec[CORDIC_STAGES]),
        .i_side     (w_side[CORDIC_STAGES]),
        .o_valid    (w_out_valid),
        .o_vel_x    (m_axis_tdata[0*VEL_W +: VEL_W]),
        .o_vel_y    (m_axis_tdata[1*VEL_W +: VEL_W]),
        .o_vel_turn (m_axis_tdata[2*VEL_W +: VEL_W])
    );

endmodule

`default_nettype wire

// ----- rtl/jtcv_checker.sv -----
// Port-level checks for joystick_to_chassis_velocity, bound to the top level.
`default_nettype none

`include "joystick_to_chassis_velocity_defines.svh"

module jtcv_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [jtcv_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // a stalled result stays put
    `JTCV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

    // input side stalls exactly when a result is stuck at the output
    `JTCV_ASSERT_NOW(a_ready_link, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output backpressure")

    // reset empties the pipeline
    `JTCV_ASSERT_RST(a_rst_empty, !m_axis_tvalid, "output valid after reset")

endmodule

bind joystick_to_chassis_velocity jtcv_checker u_jtcv_checker (.*);

`default_nettype wire
